// ----- hw/rtl/rsb_pkg.sv -----
// Shared constants, widths and controller/datapath interface types for the sprite blitter.
package rsb_pkg;

	// Largest sprite side; wider or taller requests saturate to this
	localparam int MAX_DIM     = 32;
	// Sprite store depth in bytes (a power of two, so the address wraps by truncation)
	localparam int STORE_BYTES = 128;

	// Field widths fixed by the interface
	localparam int POS_W   = 10;
	localparam int SIZE_W  = 6;
	localparam int TRIG_W  = 16;
	localparam int SCR_W   = 11;
	localparam int MASK_W  = 64;
	localparam int BADDR_W = 7;
	localparam int BYTE_W  = 8;
	localparam int FRAC_W  = 14;

	// Derived widths
	localparam int ADDR_W  = $clog2(STORE_BYTES);
	localparam int DIM_W   = $clog2(MAX_DIM + 1);
	localparam int RAD_W   = $clog2(MAX_DIM + 1);
	localparam int SPAN_W  = RAD_W + 1;
	localparam int NSQ_W   = $clog2(2 * MAX_DIM * MAX_DIM + 1);
	localparam int ROOT_W  = $clog2(2 * MAX_DIM + 1);
	localparam int PROD_W  = RAD_W + 1 + TRIG_W;
	localparam int ACC_W   = TRIG_W + 2 + $clog2(MAX_DIM + 1) + 1;
	localparam int IX_W    = ACC_W - FRAC_W - 1;
	localparam int BPR_W   = $clog2(MAX_DIM / 8 + 2);
	localparam int AF_W    = DIM_W + BPR_W + 1;
	localparam int BSEL_W  = $clog2(BYTE_W);
	localparam int KIDX_W  = $clog2(MASK_W);

	// Action codes
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_DRAW = 1'b1;

	// Controller to datapath commands
	typedef struct packed {
		logic              load;
		logic              capture;
		logic              root_step;
		logic              set_rad;
		logic              mul;
		logic              init;
		logic              pix;
		logic              eor;
		logic              lastrow;
		logic [SPAN_W-1:0] k;
	} rsb_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic              root_done;
		logic [SPAN_W-1:0] span;
	} rsb_stat_t;

endpackage

// ----- hw/rtl/rsb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rsb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/rsb_ctrl.sv -----
// Sequencer for the sprite blitter: root search, setup and the row/pixel scan.
module rsb_ctrl import rsb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      action,
	input  rsb_stat_t stat,
	output rsb_cmd_t  cmd,
	output logic      busy
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ROOT,
		S_MUL,
		S_INIT,
		S_RUN,
		S_DRAIN
	} state_t;

	state_t            state_q;
	logic              busy_q;
	logic [SPAN_W-1:0] kx_q;
	logic [SPAN_W-1:0] ky_q;
	logic              accept;

	assign accept = start && !busy_q;
	assign busy   = busy_q;

	// Decode commands from state
	always_comb begin
		cmd           = '0;
		cmd.k         = kx_q;
		cmd.eor       = (kx_q == stat.span);
		cmd.lastrow   = (ky_q == stat.span);
		case (state_q)
			S_IDLE: begin
				cmd.load    = accept && (action == ACT_LOAD);
				cmd.capture = accept && (action == ACT_DRAW);
			end
			S_ROOT: begin
				cmd.root_step = !stat.root_done;
				cmd.set_rad   = stat.root_done;
			end
			S_MUL:   cmd.mul  = 1'b1;
			S_INIT:  cmd.init = 1'b1;
			S_RUN:   cmd.pix  = 1'b1;
			S_DRAIN: cmd.pix  = 1'b0;
			default: cmd.pix  = 1'b0;
		endcase
	end

	// Hold state, busy flag and scan counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			kx_q    <= '0;
			ky_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && (action == ACT_DRAW)) begin
						state_q <= S_ROOT;
						busy_q  <= 1'b1;
					end
				end
				S_ROOT: begin
					if (stat.root_done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_INIT;
				S_INIT: begin
					kx_q    <= '0;
					ky_q    <= '0;
					state_q <= S_RUN;
				end
				S_RUN: begin
					if (cmd.eor) begin
						kx_q <= '0;
						ky_q <= ky_q + SPAN_W'(1);
						if (cmd.lastrow) begin
							state_q <= S_DRAIN;
						end
					end else begin
						kx_q <= kx_q + SPAN_W'(1);
					end
				end
				S_DRAIN: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

endmodule

// ----- hw/rtl/rsb_dp.sv -----
// Datapath for the sprite blitter: sprite store, root unit, coordinate walk and row masks.
module rsb_dp import rsb_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  rsb_cmd_t                 cmd,
	output rsb_stat_t                stat,
	input  logic [BADDR_W-1:0]       byte_addr,
	input  logic [BYTE_W-1:0]        byte_data,
	input  logic signed [POS_W-1:0]  pos_x,
	input  logic signed [POS_W-1:0]  pos_y,
	input  logic [SIZE_W-1:0]        sprite_width,
	input  logic [SIZE_W-1:0]        sprite_height,
	input  logic signed [TRIG_W-1:0] cos_q,
	input  logic signed [TRIG_W-1:0] sin_q,
	output logic                     strobe,
	output logic signed [SCR_W-1:0]  row_y,
	output logic signed [SCR_W-1:0]  left_x,
	output logic [MASK_W-1:0]        row_mask,
	output logic                     last
);

	// Draw parameters
	logic signed [POS_W-1:0]  px_q, py_q;
	logic [DIM_W-1:0]         w_q, h_q;
	logic signed [TRIG_W-1:0] c_q, s_q;
	logic [NSQ_W-1:0]         n_q;
	logic [ROOT_W-1:0]        root_q;
	logic [RAD_W-1:0]         rad_q;
	logic signed [PROD_W-1:0] rc_q, rs_q;
	logic signed [ACC_W-1:0]  sx_row_q, sy_row_q, sx_q, sy_q;
	logic signed [SCR_W-1:0]  rowy_q;

	// Pipeline and output registers
	logic                     pv_s1, eor_s1, last_s1;
	logic [BSEL_W-1:0]        bsel_s1;
	logic [KIDX_W-1:0]        k_s1;
	logic [MASK_W-1:0]        mask_q;
	logic                     strobe_q;

	// Combinational helpers
	logic [DIM_W-1:0]         w_sat, h_sat;
	logic [NSQ_W-1:0]         nsq_c;
	logic [ROOT_W:0]          root_nx;
	logic [2*ROOT_W+1:0]      root_sq;
	logic signed [PROD_W-1:0] rc_c, rs_c;
	logic signed [ACC_W-1:0]  wq13, hq13;
	logic                     x_ok, y_ok, in_x, in_y;
	logic [IX_W-1:0]          ix_full, iy_full;
	logic [DIM_W-1:0]         ix, iy;
	logic [BPR_W-1:0]         bpr;
	logic [AF_W-1:0]          addr_full;
	logic [ADDR_W-1:0]        rd_addr;
	logic [BYTE_W-1:0]        rd_data;
	logic                     hit;
	logic [MASK_W-1:0]        bitvec;

	// Saturate sprite size and form w*w + h*h
	assign w_sat = (sprite_width  > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(sprite_width);
	assign h_sat = (sprite_height > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(sprite_height);
	assign nsq_c = NSQ_W'(w_sat) * NSQ_W'(w_sat) + NSQ_W'(h_sat) * NSQ_W'(h_sat);

	// Integer square root by upward search
	assign root_nx        = (ROOT_W + 1)'(root_q) + (ROOT_W + 1)'(1);
	assign root_sq        = (2 * ROOT_W + 2)'(root_nx) * (2 * ROOT_W + 2)'(root_nx);
	assign stat.root_done = root_sq > (2 * ROOT_W + 2)'(n_q);
	assign stat.span      = SPAN_W'({rad_q, 1'b0});

	// Radius times cosine and sine
	assign rc_c = $signed({1'b0, rad_q}) * c_q;
	assign rs_c = $signed({1'b0, rad_q}) * s_q;
	assign wq13 = ACC_W'($signed({1'b0, w_q, {(FRAC_W - 1){1'b0}}}));
	assign hq13 = ACC_W'($signed({1'b0, h_q, {(FRAC_W - 1){1'b0}}}));

	// Truncate source coordinates toward zero and test bounds
	assign x_ok    = !sx_q[ACC_W-1] ||
	                 ((&sx_q[ACC_W-1:FRAC_W]) && (|sx_q[FRAC_W-1:0]));
	assign y_ok    = !sy_q[ACC_W-1] ||
	                 ((&sy_q[ACC_W-1:FRAC_W]) && (|sy_q[FRAC_W-1:0]));
	assign ix_full = sx_q[ACC_W-1] ? '0 : sx_q[ACC_W-2:FRAC_W];
	assign iy_full = sy_q[ACC_W-1] ? '0 : sy_q[ACC_W-2:FRAC_W];
	assign in_x    = x_ok && (ix_full < IX_W'(w_q));
	assign in_y    = y_ok && (iy_full < IX_W'(h_q));
	assign ix      = DIM_W'(ix_full);
	assign iy      = DIM_W'(iy_full);

	// Byte address of the source pixel
	assign bpr       = BPR_W'(({1'b0, w_q} + (DIM_W + 1)'(7)) >> 3);
	assign addr_full = AF_W'(iy) * AF_W'(bpr) + AF_W'(ix >> 3);
	assign rd_addr   = ADDR_W'(addr_full);

	rsb_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (STORE_BYTES)
	) u_store (
		.clk   (clk),
		.we    (cmd.load),
		.waddr (ADDR_W'(byte_addr)),
		.wdata (byte_data),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// Select the pixel bit once the byte is back
	assign hit    = pv_s1 && rd_data[bsel_s1];
	assign bitvec = hit ? (MASK_W'(1) << k_s1) : '0;

	// Capture draw, run root search, set up and walk source coordinates
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			px_q   <= pos_x;
			py_q   <= pos_y;
			w_q    <= w_sat;
			h_q    <= h_sat;
			c_q    <= cos_q;
			s_q    <= sin_q;
			n_q    <= nsq_c;
			root_q <= '0;
		end
		if (cmd.root_step) begin
			root_q <= ROOT_W'(root_nx);
		end
		if (cmd.set_rad) begin
			rad_q <= RAD_W'(root_q >> 1) + RAD_W'(2);
		end
		if (cmd.mul) begin
			rc_q <= rc_c;
			rs_q <= rs_c;
		end
		if (cmd.init) begin
			sx_row_q <= wq13 - ACC_W'(rc_q) - ACC_W'(rs_q);
			sy_row_q <= hq13 + ACC_W'(rs_q) - ACC_W'(rc_q);
			sx_q     <= wq13 - ACC_W'(rc_q) - ACC_W'(rs_q);
			sy_q     <= hq13 + ACC_W'(rs_q) - ACC_W'(rc_q);
		end
		if (cmd.pix) begin
			if (cmd.eor) begin
				sx_row_q <= sx_row_q + ACC_W'(s_q);
				sy_row_q <= sy_row_q + ACC_W'(c_q);
				sx_q     <= sx_row_q + ACC_W'(s_q);
				sy_q     <= sy_row_q + ACC_W'(c_q);
			end else begin
				sx_q <= sx_q + ACC_W'(c_q);
				sy_q <= sy_q - ACC_W'(s_q);
			end
		end
		bsel_s1 <= BSEL_W'(~ix[BSEL_W-1:0]);
		k_s1    <= KIDX_W'(cmd.k);
		last_s1 <= cmd.lastrow;
	end

	// Track pixel-stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1    <= 1'b0;
			eor_s1   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			pv_s1    <= cmd.pix && in_x && in_y;
			eor_s1   <= cmd.pix && cmd.eor;
			strobe_q <= eor_s1;
		end
	end

	// Accumulate row mask and emit one transaction per destination row
	always_ff @(posedge clk) begin
		if (cmd.init) begin
			mask_q <= '0;
			rowy_q <= SCR_W'(py_q) - SCR_W'(rad_q);
			left_x <= SCR_W'(px_q) - SCR_W'(rad_q);
		end else if (eor_s1) begin
			mask_q   <= '0;
			row_mask <= mask_q | bitvec;
			row_y    <= rowy_q;
			last     <= last_s1;
			rowy_q   <= rowy_q + SCR_W'(1);
		end else begin
			mask_q <= mask_q | bitvec;
		end
	end

	assign strobe = strobe_q;

endmodule

// ----- hw/rtl/rotated_sprite_blitter.sv -----
// Rotated 1-bit sprite blitter: top level joining the sequencer and the datapath.
//
// Usage: a transaction is taken when start is high and busy is low. With action
// low it writes byte_data into the sprite store at byte_addr and busy stays
// low. With action high it draws the stored sprite rotated about its centre by
// the given cosine and sine (signed Q2.14), nearest-neighbour.
// A draw first finds R = floor(isqrt(w*w + h*h) / 2) + 2 with an upward root
// search, multiplies R by the cosine and sine and sets up the walk, then scans
// the (2R+1) by (2R+1) destination square at one pixel per cycle through the
// store's single read port, one row mask per destination row. Busy stays high
// while the draw runs and falls once the scan is done. Each row is shown for
// one cycle with strobe high; the receiver cannot stall it, and last marks the
// final row. The last row may appear in the cycle when busy has already fallen.
// Reset clears the sequencer; the sprite store holds no defined contents until
// loaded, and drawing unloaded bytes is not allowed.
module rotated_sprite_blitter import rsb_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic                     action,
	input  logic [BADDR_W-1:0]       byte_addr,
	input  logic [BYTE_W-1:0]        byte_data,
	input  logic signed [POS_W-1:0]  pos_x,
	input  logic signed [POS_W-1:0]  pos_y,
	input  logic [SIZE_W-1:0]        sprite_width,
	input  logic [SIZE_W-1:0]        sprite_height,
	input  logic signed [TRIG_W-1:0] cos_q,
	input  logic signed [TRIG_W-1:0] sin_q,
	output logic                     strobe,
	output logic signed [SCR_W-1:0]  row_y,
	output logic signed [SCR_W-1:0]  left_x,
	output logic [MASK_W-1:0]        row_mask,
	output logic                     last
);

	rsb_cmd_t  cmd;
	rsb_stat_t stat;

	rsb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	rsb_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.byte_addr     (byte_addr),
		.byte_data     (byte_data),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.sprite_width  (sprite_width),
		.sprite_height (sprite_height),
		.cos_q         (cos_q),
		.sin_q         (sin_q),
		.strobe        (strobe),
		.row_y         (row_y),
		.left_x        (left_x),
		.row_mask      (row_mask),
		.last          (last)
	);

	// A draw transaction must raise busy in the next cycle
	a_draw_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (action == ACT_DRAW) |=> busy)
		else $error("draw accepted without raising busy");

	// A row other than the final one leaves while the scan is still running
	a_row_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("non-final row emitted after scan ended");

	// No row directly follows the final row of a draw
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe)
		else $error("row emitted right after final row");

	// Loads are issued only when the block is idle
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !busy && !cmd.pix)
		else $error("store write during a draw");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the rotated sprite blitter: queued stimulus, predictor, row checker.
`timescale 1ns / 1ps

module testbench import rsb_pkg::*;;

	// One transaction as the driver presents it
	typedef struct {
		logic                     act;
		logic [BADDR_W-1:0]       addr;
		logic [BYTE_W-1:0]        data;
		logic signed [POS_W-1:0]  px;
		logic signed [POS_W-1:0]  py;
		logic [SIZE_W-1:0]        w;
		logic [SIZE_W-1:0]        h;
		logic signed [TRIG_W-1:0] c;
		logic signed [TRIG_W-1:0] s;
		bit                       drain;
	} blit_item_t;

	// One expected destination row
	typedef struct packed {
		logic signed [SCR_W-1:0] row_y;
		logic signed [SCR_W-1:0] left_x;
		logic [MASK_W-1:0]       row_mask;
		logic                    last;
	} row_exp_t;

	localparam int Q_ONE = 1 << FRAC_W;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     action = 1'b0;
	logic [BADDR_W-1:0]       byte_addr = '0;
	logic [BYTE_W-1:0]        byte_data = '0;
	logic signed [POS_W-1:0]  pos_x = '0;
	logic signed [POS_W-1:0]  pos_y = '0;
	logic [SIZE_W-1:0]        sprite_width = '0;
	logic [SIZE_W-1:0]        sprite_height = '0;
	logic signed [TRIG_W-1:0] cos_q = '0;
	logic signed [TRIG_W-1:0] sin_q = '0;
	logic                     busy;
	logic                     strobe;
	logic signed [SCR_W-1:0]  row_y;
	logic signed [SCR_W-1:0]  left_x;
	logic [MASK_W-1:0]        row_mask;
	logic                     last;

	blit_item_t               blit_q[$];
	row_exp_t                 expected_rows[$];
	logic [BYTE_W-1:0]        sprite_mem[STORE_BYTES];
	logic [STORE_BYTES-1:0]   loaded = '0;
	blit_item_t               cur_item;
	int                       n_sent = 0;
	int                       n_total = 0;
	int                       mismatches = 0;

	rotated_sprite_blitter dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .action(action),
		.byte_addr(byte_addr), .byte_data(byte_data), .pos_x(pos_x), .pos_y(pos_y),
		.sprite_width(sprite_width), .sprite_height(sprite_height),
		.cos_q(cos_q), .sin_q(sin_q), .strobe(strobe), .row_y(row_y),
		.left_x(left_x), .row_mask(row_mask), .last(last)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		$display("%0t ns mismatch: %s got %h expected %h", $realtime, what, got, want);
	endtask

	function automatic int root_floor(input int n);
		int q;
		q = 0;
		while ((q + 1) * (q + 1) <= n) q++;
		return q;
	endfunction

	// Truncate a Q14 coordinate toward zero; -1 marks a negative index
	function automatic int q14_index(input int v);
		if (v <= -Q_ONE) return -1;
		if (v < 0) return 0;
		return v / Q_ONE;
	endfunction

	// Rotate one draw: return the store bytes it reads, and queue its rows when emit is set
	function automatic logic [STORE_BYTES-1:0] render_draw(input blit_item_t it, input bit emit);
		int w, h, c, s, px, py, r, bpr, sx, sy, ix, iy, addr;
		logic [MASK_W-1:0] mask;
		logic [STORE_BYTES-1:0] touched;
		row_exp_t e;
		touched = '0;
		w = it.w;
		h = it.h;
		if (w > MAX_DIM) w = MAX_DIM;
		if (h > MAX_DIM) h = MAX_DIM;
		c = it.c;
		s = it.s;
		px = it.px;
		py = it.py;
		r = root_floor(w * w + h * h) / 2 + 2;
		bpr = (w + BYTE_W - 1) / BYTE_W;
		for (int dy = -r; dy <= r; dy++) begin
			mask = '0;
			for (int dx = -r; dx <= r; dx++) begin
				sx = dx * c + dy * s + w * (Q_ONE / 2);
				sy = -dx * s + dy * c + h * (Q_ONE / 2);
				ix = q14_index(sx);
				iy = q14_index(sy);
				if (ix >= 0 && ix < w && iy >= 0 && iy < h) begin
					addr = (iy * bpr + ix / BYTE_W) % STORE_BYTES;
					touched[addr] = 1'b1;
					if (emit && sprite_mem[addr][BYTE_W - 1 - ix % BYTE_W])
						mask[dx + r] = 1'b1;
				end
			end
			if (emit) begin
				e.row_y = SCR_W'(py + dy);
				e.left_x = SCR_W'(px - r);
				e.row_mask = mask;
				e.last = (dy == r);
				expected_rows.push_back(e);
			end
		end
		return touched;
	endfunction

	function automatic blit_item_t load_item(input int addr, input int data);
		blit_item_t it;
		it.act = ACT_LOAD;
		it.addr = BADDR_W'(addr);
		it.data = BYTE_W'(data);
		it.px = POS_W'($urandom);
		it.py = POS_W'($urandom);
		it.w = SIZE_W'($urandom);
		it.h = SIZE_W'($urandom);
		it.c = TRIG_W'($urandom);
		it.s = TRIG_W'($urandom);
		it.drain = 1'b0;
		return it;
	endfunction

	function automatic blit_item_t draw_item(input int px, input int py, input int w,
			input int h, input int c, input int s);
		blit_item_t it;
		it.act = ACT_DRAW;
		it.addr = BADDR_W'($urandom);
		it.data = BYTE_W'($urandom);
		it.px = POS_W'(px);
		it.py = POS_W'(py);
		it.w = SIZE_W'(w);
		it.h = SIZE_W'(h);
		it.c = TRIG_W'(c);
		it.s = TRIG_W'(s);
		it.drain = 1'b0;
		return it;
	endfunction

	// Queue a transaction, first loading any byte a draw would read before it was written
	task automatic queue_item(input blit_item_t it);
		logic [STORE_BYTES-1:0] need;
		bit d;
		blit_item_t ld;
		d = it.drain;
		it.drain = 1'b0;
		if (it.act == ACT_DRAW) begin
			need = render_draw(it, 1'b0) & ~loaded;
			for (int i = 0; i < STORE_BYTES; i++) begin
				if (need[i]) begin
					ld = load_item(i, $urandom_range(255));
					ld.drain = d;
					d = 1'b0;
					loaded[i] = 1'b1;
					blit_q.push_back(ld);
				end
			end
		end else begin
			loaded[it.addr] = 1'b1;
		end
		it.drain = d;
		blit_q.push_back(it);
	endtask

	// Driver: hold start until accepted, update the predictor on each accepted transaction
	always @(posedge clk) begin : drive
		bit accepted, hold_off, blocked;
		int phase;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			accepted = start && !busy;
			if (accepted) begin
				if (cur_item.act == ACT_LOAD)
					sprite_mem[cur_item.addr] = cur_item.data;
				else
					void'(render_draw(cur_item, 1'b1));
				n_sent++;
			end
			phase = (n_sent * 3 < n_total) ? 0 : (n_sent * 3 < 2 * n_total) ? 1 : 2;
			hold_off = (phase == 0) ? ($urandom_range(99) < 23) :
			           (phase == 1) ? ($urandom_range(99) < 55) : 1'b0;
			blocked = blit_q.size() == 0 ||
				(blit_q[0].drain && (expected_rows.size() != 0 || busy || strobe));
			if (start && !accepted) begin
				// hold the current transaction
			end else if (!blocked && !hold_off) begin
				cur_item = blit_q.pop_front();
				action <= cur_item.act;
				byte_addr <= cur_item.addr;
				byte_data <= cur_item.data;
				pos_x <= cur_item.px;
				pos_y <= cur_item.py;
				sprite_width <= cur_item.w;
				sprite_height <= cur_item.h;
				cos_q <= cur_item.c;
				sin_q <= cur_item.s;
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: check each strobed row against the oldest expected row
	always @(posedge clk) begin : monitor
		row_exp_t want;
		if (arst_n && strobe) begin
			if (expected_rows.size() == 0) begin
				report_mismatch("row with nothing expected", row_mask, '0);
			end else begin
				want = expected_rows.pop_front();
				if (row_y !== want.row_y) report_mismatch("row_y", row_y, want.row_y);
				if (left_x !== want.left_x) report_mismatch("left_x", left_x, want.left_x);
				if (row_mask !== want.row_mask)
					report_mismatch("row_mask", row_mask, want.row_mask);
				if (last !== want.last) report_mismatch("last", last, want.last);
			end
		end
	end

	// Stimulus, reset and end of run
	initial begin : stimulus
		blit_item_t it;
		int n_directed, sel, k, c, s, w, h;
		real ang;
		for (int i = 0; i < STORE_BYTES; i++) sprite_mem[i] = '0;

		// Directed: field extremes, zero and oversize sprites, odd trig patterns
		queue_item(load_item(0, 8'hFF));
		queue_item(load_item(STORE_BYTES - 1, 8'h00));
		queue_item(load_item(7'h55, 8'hAA));
		queue_item(load_item(7'h2A, 8'h55));
		queue_item(draw_item(0, 0, 1, 1, Q_ONE, 0));
		queue_item(draw_item(-512, -512, 8, 8, Q_ONE, 0));
		queue_item(draw_item(511, 511, 8, 8, -Q_ONE, 0));
		queue_item(draw_item(0, 0, 0, 0, Q_ONE, 0));
		queue_item(draw_item(10, -10, 0, 7, 0, Q_ONE));
		queue_item(draw_item(-10, 10, 7, 0, 11585, 11585));
		queue_item(draw_item(100, 100, 63, 63, 0, Q_ONE));
		queue_item(draw_item(-300, 200, 32, 32, 11585, -11585));
		queue_item(draw_item(0, 0, 40, 5, 16'sh7FFF, 16'sh8000));
		queue_item(draw_item(3, 3, 13, 9, 0, 0));
		queue_item(draw_item(-1, 1, 9, 17, -Q_ONE, -Q_ONE));
		queue_item(draw_item(511, -512, 33, 2, 16'sh8000, 16'sh7FFF));
		queue_item(draw_item(0, 0, 16, 16, Q_ONE, Q_ONE));
		n_directed = blit_q.size();

		// Random: mostly small sprites at real angles, with stray loads overwriting bytes
		while (blit_q.size() < 240) begin
			if ($urandom_range(99) < 40) begin
				it = load_item($urandom_range(STORE_BYTES - 1), $urandom_range(255));
			end else begin
				sel = $urandom_range(99);
				w = (sel < 85) ? $urandom_range(12) : (sel < 95) ? $urandom_range(32, 13) :
					$urandom_range(63, 33);
				sel = $urandom_range(99);
				h = (sel < 85) ? $urandom_range(12) : (sel < 95) ? $urandom_range(32, 13) :
					$urandom_range(63, 33);
				sel = $urandom_range(99);
				if (sel < 60) begin
					ang = $urandom_range(3599) * 3.14159265358979 / 1800.0;
					c = int'($cos(ang) * Q_ONE);
					s = int'($sin(ang) * Q_ONE);
				end else if (sel < 75) begin
					k = $urandom_range(3);
					c = (k == 0) ? Q_ONE : (k == 2) ? -Q_ONE : 0;
					s = (k == 1) ? Q_ONE : (k == 3) ? -Q_ONE : 0;
				end else begin
					c = $urandom;
					s = $urandom;
				end
				it = draw_item($urandom, $urandom, w, h, c, s);
			end
			it.drain = (blit_q.size() == n_directed) || ($urandom_range(99) < 3);
			queue_item(it);
		end
		n_total = blit_q.size();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Wait until every transaction is accepted and every row has come, then idle a little
		while (n_sent < n_total || busy || expected_rows.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Watchdog
	initial begin
		#30_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
